// ===== rtl/mt64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt64_pkg
// Shared constants and types for the 64-bit Mersenne Twister generator.
// ----------------------------------------------------------------------------
package mt64_pkg;

    localparam int WORD_W         = 64;
    localparam int COUNT_W        = 7;
    localparam int STATE_WORDS_DEF = 312;
    localparam int TWIST_OFFSET   = 156;
    localparam int MAX_COUNT      = 64;

    localparam logic [WORD_W-1:0] MATRIX_A   = 64'hB5026F5AA96619E9;
    localparam logic [WORD_W-1:0] UPPER_MASK = 64'hFFFFFFFF80000000;
    localparam logic [WORD_W-1:0] LOWER_MASK = 64'h000000007FFFFFFF;
    localparam logic [WORD_W-1:0] TEMPER_D   = 64'h5555555555555555;
    localparam logic [WORD_W-1:0] TEMPER_B   = 64'h71D67FFFEDA60000;
    localparam logic [WORD_W-1:0] TEMPER_C   = 64'hFFF7EEE000000000;
    localparam logic [WORD_W-1:0] RESET_SEED = 64'd19650218;

    // 6364136223846793005 split into 32-bit halves for the shared multiplier
    localparam logic [31:0] SEED_MULT_LO = 32'h4C957F2D;
    localparam logic [31:0] SEED_MULT_HI = 32'h5851F42D;

    localparam int SHIFT_U = 29;
    localparam int SHIFT_S = 17;
    localparam int SHIFT_T = 37;
    localparam int SHIFT_L = 43;
    localparam int SEED_SHIFT = 62;

    typedef enum logic [5:0] {
        FILL_WRITE = 6'b000001,
        FILL_MUL0  = 6'b000010,
        FILL_MUL1  = 6'b000100,
        FILL_MUL2  = 6'b001000,
        FILL_SUM   = 6'b010000,
        FILL_DONE  = 6'b100000
    } fill_state_t;

    typedef struct packed {
        logic busy;
        logic wr_en;
    } fill_status_t;

endpackage

// ===== rtl/mt64_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt64_ram
// Generic RAM: one write port, two registered read ports with read enable.
// ----------------------------------------------------------------------------
module mt64_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read returns the old contents on a same-address write
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/mt64_seed_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt64_seed_fill
// Seeding sequencer: walks the ring and writes the seeding recurrence,
// using one shared 32x32 multiplier for three partial products per word.
// ----------------------------------------------------------------------------
module mt64_seed_fill #(
    parameter int STATE_WORDS = mt64_pkg::STATE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mt64_pkg::WORD_W-1:0]    seed,
    output mt64_pkg::fill_status_t         status,
    output logic [$clog2(STATE_WORDS)-1:0] wr_addr,
    output logic [mt64_pkg::WORD_W-1:0]    wr_data
);

    localparam int AW = $clog2(STATE_WORDS);

    mt64_pkg::fill_state_t state_reg, state_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [mt64_pkg::WORD_W-1:0] s_reg, s_next;
    logic [mt64_pkg::WORD_W-1:0] t_reg, t_next;
    logic [mt64_pkg::WORD_W-1:0] lo_reg, lo_next;
    logic [31:0]                 hi_reg, hi_next;
    logic [63:0]                 mul_reg, mul_next;
    logic [31:0]                 mul_a, mul_b;
    logic [31:0]                 hi_sum;
    logic [AW-1:0]               idx_inc;
    logic                        fill_we;

    assign idx_inc = idx_reg + AW'(1);
    assign hi_sum  = hi_reg + mul_reg[31:0];
    assign mul_next = {32'b0, mul_a} * {32'b0, mul_b};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        s_next     = s_reg;
        t_next     = t_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mul_a      = t_reg[31:0];
        mul_b      = mt64_pkg::SEED_MULT_LO;
        fill_we    = 1'b0;
        unique case (state_reg)
            mt64_pkg::FILL_WRITE:
            begin
                fill_we = 1'b1;
                t_next = s_reg ^ (s_reg >> mt64_pkg::SEED_SHIFT);
                if (idx_reg == AW'(STATE_WORDS - 1))
                begin
                    state_next = mt64_pkg::FILL_DONE;
                end
                else
                begin
                    state_next = mt64_pkg::FILL_MUL0;
                end
            end
            mt64_pkg::FILL_MUL0:
            begin
                // low x low
                state_next = mt64_pkg::FILL_MUL1;
            end
            mt64_pkg::FILL_MUL1:
            begin
                mul_b      = mt64_pkg::SEED_MULT_HI;
                lo_next    = mul_reg;
                state_next = mt64_pkg::FILL_MUL2;
            end
            mt64_pkg::FILL_MUL2:
            begin
                mul_a      = t_reg[63:32];
                hi_next    = mul_reg[31:0];
                state_next = mt64_pkg::FILL_SUM;
            end
            mt64_pkg::FILL_SUM:
            begin
                s_next     = lo_reg + {hi_sum, 32'b0} + mt64_pkg::WORD_W'(idx_inc);
                idx_next   = idx_inc;
                state_next = mt64_pkg::FILL_WRITE;
            end
            mt64_pkg::FILL_DONE:
            begin
                state_next = mt64_pkg::FILL_DONE;
            end
            default:
            begin
                state_next = mt64_pkg::FILL_DONE;
            end
        endcase
        if (start)
        begin
            state_next = mt64_pkg::FILL_WRITE;
            idx_next   = '0;
            s_next     = seed;
        end
    end

    assign status  = '{busy: (state_reg != mt64_pkg::FILL_DONE), wr_en: fill_we};
    assign wr_addr = idx_reg;
    assign wr_data = s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mt64_pkg::FILL_WRITE;
            idx_reg   <= '0;
            s_reg     <= mt64_pkg::RESET_SEED;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            s_reg     <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mul_reg <= mul_next;
    end

endmodule

// ===== rtl/mt64_twist_temper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt64_twist_temper
// Twist of one ring word and tempering of the new word.
// ----------------------------------------------------------------------------
module mt64_twist_temper (
    input  logic [mt64_pkg::WORD_W-1:0] head_word,
    input  logic [mt64_pkg::WORD_W-1:0] next_word,
    input  logic [mt64_pkg::WORD_W-1:0] mid_word,
    output logic [mt64_pkg::WORD_W-1:0] new_word,
    output logic [mt64_pkg::WORD_W-1:0] tempered
);

    logic [mt64_pkg::WORD_W-1:0] x, xa, y0, y1, y2;

    always_comb
    begin
        x  = (head_word & mt64_pkg::UPPER_MASK) | (next_word & mt64_pkg::LOWER_MASK);
        xa = x >> 1;
        if (x[0])
        begin
            xa = xa ^ mt64_pkg::MATRIX_A;
        end
        new_word = mid_word ^ xa;
        y0 = new_word ^ ((new_word >> mt64_pkg::SHIFT_U) & mt64_pkg::TEMPER_D);
        y1 = y0 ^ ((y0 << mt64_pkg::SHIFT_S) & mt64_pkg::TEMPER_B);
        y2 = y1 ^ ((y1 << mt64_pkg::SHIFT_T) & mt64_pkg::TEMPER_C);
        tempered = y2 ^ (y2 >> mt64_pkg::SHIFT_L);
    end

endmodule

// ===== rtl/mersenne_twister_64_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_64_generator
// MT19937-64 generator with its state ring held in a two-read-port RAM.
// ----------------------------------------------------------------------------
// Flow: an accepted request issues its values into the ring read stage, then the
//   output register; they follow one per cycle while rsp_stall is low.
// Requests: a request of n values (n <= 64) takes one ring read/twist/write-back
//   per value; a new request is held until the read stage has drained.
// Reset: the ring fills with the seeding recurrence of seed 19650218; a seed
//   write restarts it.
// ----------------------------------------------------------------------------
module mersenne_twister_64_generator #(
    parameter int STATE_WORDS = mt64_pkg::STATE_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [mt64_pkg::COUNT_W-1:0]        value_count,
    // result channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [mt64_pkg::WORD_W-1:0]         random_value,
    output logic                                last,
    // seed register write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mt64_pkg::WORD_W-1:0]         cfg_data
);

    localparam int AW = $clog2(STATE_WORDS);

    // ring position and the current contents of the word at it
    logic [AW-1:0]               pos_reg, pos_next;
    logic [mt64_pkg::WORD_W-1:0] head_reg, head_next;
    logic [mt64_pkg::COUNT_W-1:0] remain_reg, remain_next;

    // read-data stage
    logic                        d_valid_reg, d_valid_next;
    logic                        d_last_reg, d_last_next;
    logic [AW-1:0]               d_pos_reg, d_pos_next;
    logic                        fwd_reg, fwd_next;
    logic [mt64_pkg::WORD_W-1:0] fwd_data_reg, fwd_data_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [mt64_pkg::WORD_W-1:0] out_value_reg, out_value_next;
    logic                        out_last_reg, out_last_next;

    logic                        advance, issue, accept, cfg_write;
    logic [AW:0]                 pos_plus1, pos_plusm;
    logic [AW-1:0]               k1_addr, km_addr;
    logic [mt64_pkg::COUNT_W-1:0] sat_count;

    mt64_pkg::fill_status_t      fill_status;
    logic [AW-1:0]               fill_addr;
    logic [mt64_pkg::WORD_W-1:0] fill_data;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [mt64_pkg::WORD_W-1:0] ram_wdata;
    logic [mt64_pkg::WORD_W-1:0] rd_next, rd_mid, mid_word;
    logic [mt64_pkg::WORD_W-1:0] new_word, tempered;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Hold requests while the ring fills or a request is still in flight.
    assign req_stall = fill_status.busy || (remain_reg != '0) || d_valid_reg;
    assign accept    = req_valid && !req_stall;

    // Advance the read pipeline whenever the output register can take a value.
    assign advance = !out_valid_reg || !rsp_stall;
    assign issue   = advance && (remain_reg != '0);

    // Neighbor addresses of the word being issued, wrapped around the ring.
    assign pos_plus1 = {1'b0, pos_reg} + (AW+1)'(1);
    assign pos_plusm = {1'b0, pos_reg} + (AW+1)'(mt64_pkg::TWIST_OFFSET);
    assign k1_addr = (pos_plus1 >= (AW+1)'(STATE_WORDS))
                     ? AW'(pos_plus1 - (AW+1)'(STATE_WORDS)) : AW'(pos_plus1);
    assign km_addr = (pos_plusm >= (AW+1)'(STATE_WORDS))
                     ? AW'(pos_plusm - (AW+1)'(STATE_WORDS)) : AW'(pos_plusm);

    // Saturate oversized counts to the burst limit.
    assign sat_count = (value_count > mt64_pkg::COUNT_W'(mt64_pkg::MAX_COUNT))
                       ? mt64_pkg::COUNT_W'(mt64_pkg::MAX_COUNT) : value_count;

    mt64_seed_fill #(
        .STATE_WORDS (STATE_WORDS)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_write),
        .seed    (cfg_data),
        .status  (fill_status),
        .wr_addr (fill_addr),
        .wr_data (fill_data)
    );

    // The fill write takes priority over a generator write-back in the same cycle.
    always_comb
    begin
        if (fill_status.wr_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = fill_addr;
            ram_wdata = fill_data;
        end
        else
        begin
            ram_we    = advance && d_valid_reg;
            ram_waddr = d_pos_reg;
            ram_wdata = new_word;
        end
    end

    mt64_ram #(
        .WIDTH (mt64_pkg::WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_ring (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (issue),
        .raddr_a (k1_addr),
        .raddr_b (km_addr),
        .rdata_a (rd_next),
        .rdata_b (rd_mid)
    );

    // On a small ring the offset word can be the one written in the issue
    // cycle; the RAM returns stale data then, so take the forwarded copy.
    assign mid_word = fwd_reg ? fwd_data_reg : rd_mid;

    mt64_twist_temper u_twist (
        .head_word (head_reg),
        .next_word (rd_next),
        .mid_word  (mid_word),
        .new_word  (new_word),
        .tempered  (tempered)
    );

    always_comb
    begin
        pos_next       = pos_reg;
        head_next      = head_reg;
        remain_next    = remain_reg;
        d_valid_next   = d_valid_reg;
        d_last_next    = d_last_reg;
        d_pos_next     = d_pos_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        if (advance)
        begin
            // drain the read stage into the output register
            out_valid_next = d_valid_reg;
            if (d_valid_reg)
            begin
                out_value_next = tempered;
                out_last_next  = d_last_reg;
                head_next      = rd_next;
            end
            // issue the next value of the run
            d_valid_next = issue;
            if (issue)
            begin
                d_last_next   = (remain_reg == mt64_pkg::COUNT_W'(1));
                d_pos_next    = pos_reg;
                pos_next      = k1_addr;
                remain_next   = remain_reg - mt64_pkg::COUNT_W'(1);
                fwd_next      = d_valid_reg && (km_addr == d_pos_reg);
                fwd_data_next = new_word;
            end
        end

        if (accept)
        begin
            remain_next = sat_count;
        end

        // A seed write resets the position; the head word is the seed itself.
        if (cfg_write)
        begin
            pos_next  = '0;
            head_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            head_reg      <= mt64_pkg::RESET_SEED;
            remain_reg    <= '0;
            d_valid_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            head_reg      <= head_next;
            remain_reg    <= remain_next;
            d_valid_reg   <= d_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_last_reg    <= d_last_next;
        d_pos_reg     <= d_pos_next;
        fwd_data_reg  <= fwd_data_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp_valid    = out_valid_reg;
    assign random_value = out_value_reg;
    assign last         = out_last_reg;

endmodule
